[rtl/lcdr_pkg.sv]
// ----------------------------------------------------------------------------
// lcdr_pkg: shared types and constants for the character LCD refresh controller
// Action codes, sequencer step codes, the control store, the init program
// and the Cyrillic glyph table.
// ----------------------------------------------------------------------------
`default_nettype none

package lcdr_pkg;

  localparam logic [7:0] SPACE_CHAR   = 8'h20;
  localparam logic [7:0] LINE0_CMD    = 8'h80;
  localparam logic [7:0] LINE1_CMD    = 8'hC0;
  localparam logic [7:0] CYR_FIRST    = 8'hC0;
  localparam logic [5:0] POWERUP_WAIT = 6'd50;
  localparam logic [5:0] NIBBLE_WAIT  = 6'd10;
  localparam logic [5:0] CLEAR_WAIT   = 6'd2;

  typedef enum logic [2:0] {
    ACT_TICK       = 3'd0,
    ACT_PUT_CHAR   = 3'd1,
    ACT_SET_POS    = 3'd2,
    ACT_CLEAR      = 3'd3,
    ACT_REFRESH    = 3'd4,
    ACT_START_INIT = 3'd5
  } action_t;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_INIT   = 2'd1,
    MODE_PRINT  = 2'd2,
    MODE_NEWROW = 2'd3
  } mode_t;

  // Sequencer step addresses
  typedef enum logic [2:0] {
    U_IDLE    = 3'd0,
    U_STATUS  = 3'd1,
    U_CHAR_HI = 3'd2,
    U_CHAR_LO = 3'd3,
    U_CMD_HI  = 3'd4,
    U_CMD_LO  = 3'd5
  } upc_t;

  typedef enum logic [1:0] {
    SRC_STATUS = 2'd0,
    SRC_CHAR   = 2'd1,
    SRC_CMD    = 2'd2
  } src_t;

  // JMP_SINGLE ends the run after one nibble when the command is a single nibble
  typedef enum logic [1:0] {
    JMP_NEXT   = 2'd0,
    JMP_DONE   = 2'd1,
    JMP_SINGLE = 2'd2
  } jump_t;

  typedef struct packed {
    logic  emit;
    logic  lcd_wr;
    logic  rs_data;
    src_t  src;
    logic  half_lo;
    jump_t jump;
    upc_t  next;
  } ucode_t;

  typedef enum logic [2:0] {
    INIT_DELAY   = 3'd0,
    INIT_CMD1    = 3'd1,
    INIT_BYTE    = 3'd2,
    INIT_FINISH  = 3'd3,
    INIT_RESTART = 3'd4
  } init_kind_t;

  typedef struct packed {
    init_kind_t  kind;
    logic [7:0]  value;
    logic [5:0]  wait_load;
    logic [3:0]  step_next;
  } init_word_t;

  localparam logic [7:0] CYR_MAP [0:63] = '{
    8'h41, 8'hA0, 8'h42, 8'hA1, 8'hE0, 8'h45, 8'hA3, 8'hA4,
    8'hA5, 8'hA6, 8'h4B, 8'hA7, 8'h4D, 8'h48, 8'h4F, 8'hA8,
    8'h50, 8'h43, 8'h54, 8'hA9, 8'hAA, 8'h58, 8'hE1, 8'hAB,
    8'hAC, 8'hE2, 8'hAD, 8'hAE, 8'hAD, 8'hAF, 8'hB0, 8'hB1,
    8'h61, 8'hB2, 8'hB3, 8'hB4, 8'hE3, 8'h65, 8'hB6, 8'hB7,
    8'hB8, 8'hB9, 8'hBA, 8'hBB, 8'hBC, 8'hBD, 8'h6F, 8'hBE,
    8'h70, 8'h63, 8'hBF, 8'h79, 8'hE4, 8'h78, 8'hE5, 8'hC0,
    8'hC1, 8'hE6, 8'hC2, 8'hC3, 8'hC4, 8'hC5, 8'hC6, 8'hC7
  };

  // Control store: one word per sequencer step
  function automatic ucode_t ucode_word(input upc_t pc);
    ucode_t w;
    w = '{emit: 1'b0, lcd_wr: 1'b0, rs_data: 1'b0, src: SRC_STATUS,
          half_lo: 1'b0, jump: JMP_DONE, next: U_IDLE};
    unique case (pc)
      U_IDLE: begin
      end
      U_STATUS: begin
        w.emit = 1'b1;
      end
      U_CHAR_HI: begin
        w = '{emit: 1'b1, lcd_wr: 1'b1, rs_data: 1'b1, src: SRC_CHAR,
              half_lo: 1'b0, jump: JMP_NEXT, next: U_CHAR_LO};
      end
      U_CHAR_LO: begin
        w = '{emit: 1'b1, lcd_wr: 1'b1, rs_data: 1'b1, src: SRC_CHAR,
              half_lo: 1'b1, jump: JMP_DONE, next: U_IDLE};
      end
      U_CMD_HI: begin
        w = '{emit: 1'b1, lcd_wr: 1'b1, rs_data: 1'b0, src: SRC_CMD,
              half_lo: 1'b0, jump: JMP_SINGLE, next: U_CMD_LO};
      end
      U_CMD_LO: begin
        w = '{emit: 1'b1, lcd_wr: 1'b1, rs_data: 1'b0, src: SRC_CMD,
              half_lo: 1'b1, jump: JMP_DONE, next: U_IDLE};
      end
      default: begin
      end
    endcase
    return w;
  endfunction

  // Power-up program of the panel, one entry per init step
  function automatic init_word_t init_word(input logic [3:0] step);
    init_word_t w;
    w = '{kind: INIT_RESTART, value: 8'h00, wait_load: 6'd0, step_next: 4'd0};
    unique case (step)
      4'd0: w = '{kind: INIT_DELAY, value: 8'h00, wait_load: POWERUP_WAIT,
                  step_next: 4'd1};
      4'd1, 4'd2, 4'd3:
            w = '{kind: INIT_CMD1, value: 8'h03, wait_load: NIBBLE_WAIT,
                  step_next: step + 4'd1};
      4'd4: w = '{kind: INIT_CMD1, value: 8'h02, wait_load: 6'd0, step_next: 4'd5};
      4'd5: w = '{kind: INIT_BYTE, value: 8'h28, wait_load: 6'd0, step_next: 4'd6};
      4'd6: w = '{kind: INIT_BYTE, value: 8'h06, wait_load: 6'd0, step_next: 4'd7};
      4'd7: w = '{kind: INIT_BYTE, value: 8'h0C, wait_load: 6'd0, step_next: 4'd8};
      4'd8: w = '{kind: INIT_BYTE, value: 8'h01, wait_load: CLEAR_WAIT,
                  step_next: 4'd9};
      4'd9: w = '{kind: INIT_FINISH, value: 8'h00, wait_load: 6'd0, step_next: 4'd0};
      default: begin
      end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

[rtl/lcdr_frame_store.sv]
// ----------------------------------------------------------------------------
// lcdr_frame_store: character frame memory
// One write port, one registered read port, and a valid bit per entry so a
// clear is a flag reset; an entry never written since a clear reads as space.
// ----------------------------------------------------------------------------
`default_nettype none

module lcdr_frame_store #(
  parameter int DEPTH = 32
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       clear_all,
  input  wire logic                       wr_en,
  input  wire logic [$clog2(DEPTH)-1:0]   wr_addr,
  input  wire logic [7:0]                 wr_data,
  input  wire logic                       rd_en,
  input  wire logic [$clog2(DEPTH)-1:0]   rd_addr,
  output logic      [7:0]                 rd_data
);
  import lcdr_pkg::*;

  logic [7:0]       mem [DEPTH];
  logic [DEPTH-1:0] valid;
  logic [7:0]       rd_q;
  logic             rd_ok;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear_all) begin
      valid <= '0;
    end else if (wr_en) begin
      valid[wr_addr] <= 1'b1;
    end
  end

  // Hold the valid flag with the read data until the next read
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ok <= 1'b0;
    end else if (rd_en) begin
      rd_ok <= valid[rd_addr];
    end
  end

  assign rd_data = rd_ok ? rd_q : SPACE_CHAR;

endmodule

`default_nettype wire

[rtl/char_lcd_refresh_controller.sv]
// ----------------------------------------------------------------------------
// char_lcd_refresh_controller: frame buffer and refresh engine for a
// character LCD on a 4-bit nibble bus
// Stores characters, tracks a write position and, on each tick out of idle,
// steps the power-up program, prints one character or moves to the next row.
// ----------------------------------------------------------------------------
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+----------------------------------
//  item in  | start, busy (taken when   | action, char_code, row, col
//           | start=1 and busy=0)       |
//  result   | strobe (one cycle, no     | is_lcd_write, reg_select, nibble,
//           | back-pressure)            | position, position_ok, last
//
//  Results: an item that yields one result (any non-tick item, or a single
//  init nibble) ends with it; a tick that writes a full byte gives one
//  result per nibble. A tick with no bus activity returns no result and
//  keeps busy low. The sequencer issues one nibble per step.
//  A new item may be taken in the cycle that shows the last result.
//  Reset: rst (synchronous) empties the frame store via its valid bits,
//  idles the sequencer and clears the position; no clearing pass.
//  The receiver cannot stall; each result is shown for exactly one cycle.
//
`default_nettype none

module char_lcd_refresh_controller #(
  parameter int COLUMNS = 16,
  parameter int ROWS    = 2,
  parameter int CHARS   = 32
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  output logic            busy,
  input  wire logic [2:0] action,
  input  wire logic [7:0] char_code,
  input  wire logic [3:0] row,
  input  wire logic [5:0] col,
  output logic            strobe,
  output logic            is_lcd_write,
  output logic            reg_select,
  output logic [3:0]      nibble,
  output logic [5:0]      position,
  output logic            position_ok,
  output logic            last
);
  import lcdr_pkg::*;

  localparam int POS_W  = $clog2(CHARS + 1);
  localparam int ADDR_W = $clog2(CHARS);
  localparam int COL_W  = $clog2(COLUMNS);
  localparam int ROW_W  = $clog2(CHARS / COLUMNS + 2);
  localparam int MUL_W  = 12;

  localparam logic [7:0] LINE2_CMD = 8'(int'(LINE0_CMD) + COLUMNS);
  localparam logic [7:0] LINE3_CMD = 8'(int'(LINE1_CMD) + COLUMNS);

  // Architectural state
  mode_t             mode, mode_next;
  logic [POS_W-1:0]  write_position, write_position_next;
  logic [POS_W-1:0]  scan_index, scan_index_next;
  logic [COL_W-1:0]  scan_col, scan_col_next;
  logic [ROW_W-1:0]  scan_row, scan_row_next;
  logic [3:0]        init_step, init_step_next;
  logic [5:0]        wait_count, wait_count_next;

  // Sequencer and its operand registers
  upc_t              upc, upc_next, entry;
  logic [7:0]        cmd_byte, cmd_byte_next;
  logic              cmd_single, cmd_single_next;
  logic              pos_ok, pos_ok_next;

  // Frame store access
  logic              fs_clear, fs_wr, fs_rd;
  logic [7:0]        fs_wr_data, fs_rd_data;

  logic              accept;
  logic              step_done;
  ucode_t            cw;
  init_word_t        iw;
  logic [7:0]        mapped_code;
  logic [MUL_W-1:0]  pos_calc;
  logic              col_wrap;
  logic [7:0]        out_byte;
  logic              use_lo;

  assign accept = start && !busy;
  assign cw     = ucode_word(upc);
  assign iw     = init_word(init_step);

  // Cyrillic codes go through the glyph table
  assign mapped_code = (char_code >= CYR_FIRST) ? CYR_MAP[char_code[5:0]] : char_code;

  // Linear address of a one-based row and column
  assign pos_calc = (MUL_W'(row) - MUL_W'(1)) * MUL_W'(COLUMNS)
                  + MUL_W'(col) - MUL_W'(1);

  assign col_wrap = (int'(scan_col) == COLUMNS - 1);

  lcdr_frame_store #(
    .DEPTH (CHARS)
  ) u_store (
    .clk       (clk),
    .rst       (rst),
    .clear_all (fs_clear),
    .wr_en     (fs_wr),
    .wr_addr   (write_position[ADDR_W-1:0]),
    .wr_data   (fs_wr_data),
    .rd_en     (fs_rd),
    .rd_addr   (scan_index[ADDR_W-1:0]),
    .rd_data   (fs_rd_data)
  );

  // Datapath: all state updates of an item land at its acceptance edge;
  // the sequencer then only plays back the bus nibbles.
  always_comb begin
    mode_next           = mode;
    write_position_next = write_position;
    scan_index_next     = scan_index;
    scan_col_next       = scan_col;
    scan_row_next       = scan_row;
    init_step_next      = init_step;
    wait_count_next     = wait_count;
    cmd_byte_next       = cmd_byte;
    cmd_single_next     = cmd_single;
    pos_ok_next         = pos_ok;
    entry               = U_IDLE;
    fs_clear            = 1'b0;
    fs_wr               = 1'b0;
    fs_rd               = 1'b0;
    fs_wr_data          = mapped_code;

    if (accept) begin
      pos_ok_next = 1'b1;
      entry       = U_STATUS;
      unique case (action)
        ACT_TICK: begin
          entry = U_IDLE;
          unique case (mode)
            MODE_PRINT: begin
              // Read the character under the scan pointer, then advance it
              fs_rd           = (int'(scan_index) < CHARS);
              scan_index_next = scan_index + POS_W'(1);
              scan_col_next   = col_wrap ? '0 : scan_col + COL_W'(1);
              scan_row_next   = col_wrap ? scan_row + ROW_W'(1) : scan_row;
              if (col_wrap || int'(scan_index) + 1 >= CHARS) begin
                mode_next = MODE_NEWROW;
              end
              entry = U_CHAR_HI;
            end
            MODE_NEWROW: begin
              mode_next       = MODE_PRINT;
              cmd_single_next = 1'b0;
              entry           = U_CMD_HI;
              if (int'(scan_row) >= ROWS || int'(scan_index) >= CHARS) begin
                // Past the last row: home the cursor and drop to idle
                cmd_byte_next   = LINE0_CMD;
                scan_index_next = '0;
                scan_col_next   = '0;
                scan_row_next   = '0;
                mode_next       = MODE_IDLE;
              end else if (int'(scan_row) == 1) begin
                cmd_byte_next = LINE1_CMD;
              end else if (int'(scan_row) == 2) begin
                cmd_byte_next = LINE2_CMD;
              end else if (int'(scan_row) == 3) begin
                cmd_byte_next = LINE3_CMD;
              end else begin
                cmd_byte_next = LINE0_CMD;
              end
            end
            MODE_INIT: begin
              if (wait_count != 6'd0) begin
                wait_count_next = wait_count - 6'd1;
              end else begin
                wait_count_next = iw.wait_load;
                init_step_next  = iw.step_next;
                case (iw.kind)
                  INIT_CMD1, INIT_BYTE: begin
                    cmd_byte_next   = iw.value;
                    cmd_single_next = (iw.kind == INIT_CMD1);
                    entry           = U_CMD_HI;
                  end
                  INIT_FINISH: begin
                    scan_index_next = '0;
                    scan_col_next   = '0;
                    scan_row_next   = '0;
                    mode_next       = MODE_PRINT;
                  end
                  default: begin
                  end
                endcase
              end
            end
            default: begin
            end
          endcase
        end
        ACT_PUT_CHAR: begin
          // Drop zero bytes and anything past a full store
          if (int'(write_position) < CHARS && mapped_code != 8'h00) begin
            fs_wr               = 1'b1;
            write_position_next = write_position + POS_W'(1);
          end
        end
        ACT_SET_POS: begin
          if (row == 4'd0 || col == 6'd0 || pos_calc >= MUL_W'(CHARS)) begin
            pos_ok_next = 1'b0;
          end else begin
            write_position_next = POS_W'(pos_calc);
          end
        end
        ACT_CLEAR: begin
          fs_clear = 1'b1;
        end
        ACT_REFRESH: begin
          if (mode == MODE_IDLE) begin
            mode_next = MODE_PRINT;
          end
        end
        ACT_START_INIT: begin
          fs_clear            = 1'b1;
          write_position_next = '0;
          mode_next           = MODE_INIT;
        end
        default: begin
        end
      endcase
    end
  end

  // Sequencer: done or one-nibble single jumps end the run, else follow the word
  assign step_done = (cw.jump == JMP_DONE) || (cw.jump == JMP_SINGLE && cmd_single);

  always_comb begin
    if (accept) begin
      upc_next = entry;
    end else if (upc == U_IDLE || step_done) begin
      upc_next = U_IDLE;
    end else begin
      upc_next = cw.next;
    end
  end

  // Result ports follow the control word of the current step
  always_comb begin
    use_lo       = cw.half_lo || (cw.jump == JMP_SINGLE && cmd_single);
    out_byte     = (cw.src == SRC_CHAR) ? fs_rd_data : cmd_byte;
    strobe       = cw.emit;
    is_lcd_write = cw.lcd_wr;
    reg_select   = cw.rs_data;
    nibble       = 4'd0;
    if (cw.src != SRC_STATUS) begin
      nibble = use_lo ? out_byte[3:0] : out_byte[7:4];
    end
    position     = 6'(write_position);
    position_ok  = (cw.src == SRC_STATUS) ? pos_ok : 1'b1;
    last         = cw.emit && step_done;
    busy         = (upc != U_IDLE) && !step_done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= MODE_IDLE;
      write_position <= '0;
      scan_index     <= '0;
      scan_col       <= '0;
      scan_row       <= '0;
      init_step      <= 4'd0;
      wait_count     <= 6'd0;
      upc            <= U_IDLE;
      cmd_single     <= 1'b0;
      pos_ok         <= 1'b1;
    end else begin
      mode           <= mode_next;
      write_position <= write_position_next;
      scan_index     <= scan_index_next;
      scan_col       <= scan_col_next;
      scan_row       <= scan_row_next;
      init_step      <= init_step_next;
      wait_count     <= wait_count_next;
      upc            <= upc_next;
      cmd_single     <= cmd_single_next;
      pos_ok         <= pos_ok_next;
    end
  end

  // Payload register: no reset needed
  always_ff @(posedge clk) begin
    cmd_byte <= cmd_byte_next;
  end

endmodule

`default_nettype wire

[rtl/lcdr_checker.sv]
// ----------------------------------------------------------------------------
// lcdr_checker: port-level checks for the LCD refresh controller
// Watches the item and result ports and flags broken result runs.
// ----------------------------------------------------------------------------
`default_nettype none

module lcdr_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       start,
  input wire logic       busy,
  input wire logic [2:0] action,
  input wire logic       strobe,
  input wire logic       is_lcd_write,
  input wire logic       reg_select,
  input wire logic [3:0] nibble,
  input wire logic [5:0] position,
  input wire logic       last
);
  import lcdr_pkg::*;

  // A run that is not finished keeps the block busy
  a_busy_mid_run: assert property (@(posedge clk) disable iff (rst)
    strobe && !last |-> busy)
    else $error("busy low before the last result of a run");

  // The second nibble follows right after the first, same position
  a_run_continues: assert property (@(posedge clk) disable iff (rst)
    strobe && !last |=> strobe && $stable(position))
    else $error("result run broken or position moved mid run");

  // A status reply is a single quiet result
  a_status_shape: assert property (@(posedge clk) disable iff (rst)
    strobe && !is_lcd_write |-> last && !reg_select && nibble == 4'd0)
    else $error("malformed status reply");

  // Every non-tick item answers with a status reply in the next cycle
  a_status_follows: assert property (@(posedge clk) disable iff (rst)
    start && !busy && action != ACT_TICK |=> strobe && !is_lcd_write)
    else $error("missing status reply");

endmodule

bind char_lcd_refresh_controller lcdr_checker u_lcdr_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .action       (action),
  .strobe       (strobe),
  .is_lcd_write (is_lcd_write),
  .reg_select   (reg_select),
  .nibble       (nibble),
  .position     (position),
  .last         (last)
);

`default_nettype wire
